// ----- rtl/swt_pkg.sv -----
package swt_pkg;

   // Input word: one byte of the command string plus its markers.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_payload;
   } req_type;

   // Result word: one token item.
   typedef struct packed {
      logic [2:0] item_kind;
      logic [7:0] word_byte;
      logic       last_of_run;
   } rsp_type;

   // Room for all results that one input word can cause.
   localparam int MaxResults = 4;
   localparam int ResIdxW    = $clog2(MaxResults);
   localparam int ResCntW    = $clog2(MaxResults + 1);

   // Depth of the queue between the front and back parts.
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);
   localparam int QueueCntW  = $clog2(QueueDepth + 1);

   // One result without its run marker.
   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
   } res_type;

   // All results of one input word, handed from front to back.
   typedef struct packed {
      logic [ResCntW-1:0]            count;
      res_type [MaxResults-1:0]      items;
   } bundle_type;

   // Result kinds.
   localparam logic [2:0] KindByte         = 3'd0;
   localparam logic [2:0] KindWordEnd      = 3'd1;
   localparam logic [2:0] KindDone         = 3'd2;
   localparam logic [2:0] KindErrBackslash = 3'd3;
   localparam logic [2:0] KindErrQuote     = 3'd4;
   localparam logic [2:0] KindErrEmpty     = 3'd5;

   // Quote modes.
   localparam logic [1:0] ModePlain  = 2'd0;
   localparam logic [1:0] ModeDouble = 2'd1;
   localparam logic [1:0] ModeSingle = 2'd2;

   // Characters with a meaning to the tokenizer.
   localparam logic [7:0] ChSpace     = 8'h20;
   localparam logic [7:0] ChTab       = 8'h09;
   localparam logic [7:0] ChNewline   = 8'h0A;
   localparam logic [7:0] ChDquote    = 8'h22;
   localparam logic [7:0] ChSquote    = 8'h27;
   localparam logic [7:0] ChBackslash = 8'h5C;
   localparam logic [7:0] ChDollar    = 8'h24;
   localparam logic [7:0] ChBacktick  = 8'h60;

endpackage

// ----- rtl/swt_front.sv -----
module swt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  swt_pkg::req_type    req_word,
   input  logic                queue_full,
   output logic                bundle_push,
   output swt_pkg::bundle_type bundle
);

   // Tokenizer state.
   logic [1:0] mode_ff, mode_in;
   logic       word_open_ff, word_open_in;
   logic       literal_ff, literal_in;
   logic       dq_esc_ff, dq_esc_in;
   logic       seen_ff, seen_in;
   logic       accept;

   // Appends one result to a bundle.
   function automatic swt_pkg::bundle_type add_res(swt_pkg::bundle_type b,
                                                   logic [2:0] k, logic [7:0] d);
      swt_pkg::bundle_type r;
      r = b;
      r.items[b.count[swt_pkg::ResIdxW-1:0]].kind = k;
      r.items[b.count[swt_pkg::ResIdxW-1:0]].data = d;
      r.count = b.count + swt_pkg::ResCntW'(1);
      return r;
   endfunction

   // Classify the byte and the end marker, and work out the next state.
   always_comb begin
      logic [7:0] c;
      swt_pkg::bundle_type b;
      c            = req_word.data_byte;
      b            = '0;
      mode_in      = mode_ff;
      word_open_in = word_open_ff;
      literal_in   = literal_ff;
      dq_esc_in    = dq_esc_ff;
      seen_in      = seen_ff;
      if (req_word.byte_present) begin
         if (literal_in) begin
            b            = add_res(b, swt_pkg::KindByte, c);
            word_open_in = 1'b1;
            literal_in   = 1'b0;
         end else if (mode_in == swt_pkg::ModeDouble) begin
            if (dq_esc_in) begin
               dq_esc_in = 1'b0;
               if (!(c == swt_pkg::ChDquote || c == swt_pkg::ChBackslash ||
                     c == swt_pkg::ChDollar || c == swt_pkg::ChBacktick ||
                     c == swt_pkg::ChNewline)) begin
                  b = add_res(b, swt_pkg::KindByte, swt_pkg::ChBackslash);
               end
               b = add_res(b, swt_pkg::KindByte, c);
            end else if (c == swt_pkg::ChDquote) begin
               mode_in = swt_pkg::ModePlain;
            end else if (c == swt_pkg::ChBackslash) begin
               dq_esc_in = 1'b1;
            end else begin
               b = add_res(b, swt_pkg::KindByte, c);
            end
         end else if (mode_in == swt_pkg::ModeSingle) begin
            if (c == swt_pkg::ChSquote) begin
               mode_in = swt_pkg::ModePlain;
            end else begin
               b = add_res(b, swt_pkg::KindByte, c);
            end
         end else begin
            // Unquoted; the unused mode code behaves the same way.
            if (c == swt_pkg::ChSpace || c == swt_pkg::ChTab ||
                c == swt_pkg::ChNewline) begin
               if (word_open_in) begin
                  b            = add_res(b, swt_pkg::KindWordEnd, 8'h00);
                  word_open_in = 1'b0;
                  seen_in      = 1'b1;
               end
            end else if (c == swt_pkg::ChDquote) begin
               mode_in      = swt_pkg::ModeDouble;
               word_open_in = 1'b1;
            end else if (c == swt_pkg::ChSquote) begin
               mode_in      = swt_pkg::ModeSingle;
               word_open_in = 1'b1;
            end else if (c == swt_pkg::ChBackslash) begin
               literal_in   = 1'b1;
               word_open_in = 1'b1;
            end else begin
               b            = add_res(b, swt_pkg::KindByte, c);
               word_open_in = 1'b1;
            end
         end
      end
      if (req_word.end_of_payload) begin
         if (literal_in) begin
            b = add_res(b, swt_pkg::KindErrBackslash, 8'h00);
         end else if (mode_in == swt_pkg::ModeDouble || mode_in == swt_pkg::ModeSingle ||
                      dq_esc_in) begin
            b = add_res(b, swt_pkg::KindErrQuote, 8'h00);
         end else begin
            if (word_open_in) begin
               b       = add_res(b, swt_pkg::KindWordEnd, 8'h00);
               seen_in = 1'b1;
            end
            b = add_res(b, seen_in ? swt_pkg::KindDone : swt_pkg::KindErrEmpty, 8'h00);
         end
         // Every payload starts afresh.
         mode_in      = swt_pkg::ModePlain;
         word_open_in = 1'b0;
         literal_in   = 1'b0;
         dq_esc_in    = 1'b0;
         seen_in      = 1'b0;
      end
      bundle = b;
   end

   // Only words that cause results go into the queue.
   assign accept      = req_push && !queue_full;
   assign bundle_push = accept && (bundle.count != '0);

   // State update on an accepted word.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= swt_pkg::ModePlain;
         word_open_ff <= 1'b0;
         literal_ff   <= 1'b0;
         dq_esc_ff    <= 1'b0;
         seen_ff      <= 1'b0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         word_open_ff <= word_open_in;
         literal_ff   <= literal_in;
         dq_esc_ff    <= dq_esc_in;
         seen_ff      <= seen_in;
      end
   end

endmodule

// ----- rtl/swt_queue.sv -----
module swt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  swt_pkg::bundle_type push_data,
   output logic                full,
   input  logic                pop,
   output swt_pkg::bundle_type pop_data,
   output logic                empty
);

   swt_pkg::bundle_type                  slot_ff [swt_pkg::QueueDepth];
   logic [swt_pkg::QueuePtrW-1:0]        wr_ptr_ff, rd_ptr_ff;
   logic [swt_pkg::QueueCntW-1:0]        count_ff;
   logic                                 do_push, do_pop;

   assign full     = (count_ff == swt_pkg::QueueCntW'(swt_pkg::QueueDepth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + swt_pkg::QueuePtrW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + swt_pkg::QueuePtrW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + swt_pkg::QueueCntW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - swt_pkg::QueueCntW'(1);
         end
      end
   end

   // Slot storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/swt_back.sv -----
module swt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  swt_pkg::bundle_type queue_data,
   output logic                queue_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output swt_pkg::rsp_type    rsp_word
);

   swt_pkg::bundle_type          cur_ff;
   logic [swt_pkg::ResIdxW-1:0]  idx_ff;
   logic                         valid_ff;
   logic                         last;
   logic                         taken;

   // The current result is the last of its run when the index plus one reaches the count.
   assign last  = ({1'b0, idx_ff} + swt_pkg::ResCntW'(1)) == cur_ff.count;
   assign taken = valid_ff && rsp_pop;

   // Load the next bundle when idle or when the last result leaves.
   assign queue_pop = !queue_empty && (!valid_ff || (taken && last));

   assign rsp_empty            = !valid_ff;
   assign rsp_word.item_kind   = cur_ff.items[idx_ff].kind;
   assign rsp_word.word_byte   = cur_ff.items[idx_ff].data;
   assign rsp_word.last_of_run = last;

   // Step through the results of the current bundle.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else if (queue_pop) begin
         valid_ff <= 1'b1;
         idx_ff   <= '0;
      end else if (taken) begin
         if (last) begin
            valid_ff <= 1'b0;
            idx_ff   <= '0;
         end else begin
            idx_ff <= idx_ff + swt_pkg::ResIdxW'(1);
         end
      end
   end

   // Bundle payload.
   always_ff @(posedge clock) begin
      if (queue_pop) begin
         cur_ff <= queue_data;
      end
   end

   // A held bundle always has at least one result left.
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (cur_ff.count != '0))
      else $error("held bundle has no results");

   // The index never runs past the end of the bundle.
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ({1'b0, idx_ff} < cur_ff.count))
      else $error("result index beyond bundle count");

   // Taking a result that is not the last moves on to the next one.
   a_index_advance: assert property (@(posedge clock) disable iff (reset)
      (taken && !last) |=> (valid_ff &&
                            idx_ff == $past(idx_ff) + swt_pkg::ResIdxW'(1)))
      else $error("result index did not advance");

endmodule

// ----- rtl/shell_word_tokenizer_top.sv -----
// Path: the results of a taken word are written into the queue, then loaded into the back part's bundle register.
// Throughput: one input word per cycle while the queue is not full; the back part gives one
// result per cycle while results are popped, so a word with several results holds the output
// for each of them, and the four-entry queue between front and back absorbs the difference.
// Reset: synchronous, active high; clears the tokenizer state, the queue and the output.
module shell_word_tokenizer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  swt_pkg::req_type req_word,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output swt_pkg::rsp_type rsp_word
);

   logic                q_full, q_empty, q_push, q_pop;
   swt_pkg::bundle_type q_in, q_out;

   assign req_full = q_full;

   // Front part: classify bytes, keep quote state, build result bundles.
   swt_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_word    (req_word),
      .queue_full  (q_full),
      .bundle_push (q_push),
      .bundle      (q_in)
   );

   // Queue of bundles between the two parts.
   swt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   // Back part: hand out results one result at a time.
   swt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (q_empty),
      .queue_data  (q_out),
      .queue_pop   (q_pop),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_word    (rsp_word)
   );

endmodule

// ----- test/shell_word_tokenizer_checker.sv -----
`timescale 1ns / 1ps

module shell_word_tokenizer_checker
   import swt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  logic    req_full,
   input  req_type req_word,
   input  logic    rsp_empty,
   input  logic    rsp_pop,
   input  rsp_type rsp_word,
   output int      fail_count,
   output int      pending
);

   // Tokenizer state as seen by the predictor.
   logic [1:0] quote_state;
   logic       in_word;
   logic       escape_next;
   logic       dq_backslash;
   logic       word_done;

   // Tokens still owed by the block, oldest first, and the run being built.
   rsp_type predicted_tokens[$];
   rsp_type run_items[$];
   int      mismatches = 0;

   function automatic void clear_state();
      quote_state  = ModePlain;
      in_word      = 1'b0;
      escape_next  = 1'b0;
      dq_backslash = 1'b0;
      word_done    = 1'b0;
   endfunction

   function automatic void add_item(logic [2:0] kind, logic [7:0] data);
      rsp_type r;
      r.item_kind   = kind;
      r.word_byte   = data;
      r.last_of_run = 1'b0;
      run_items = {run_items, r};
   endfunction

   function automatic void end_word();
      if (in_word) begin
         add_item(KindWordEnd, 8'h00);
         in_word   = 1'b0;
         word_done = 1'b1;
      end
   endfunction

   // Works out every token that one accepted word causes.
   function automatic void tokenize_word(req_type w);
      logic [7:0] c;
      c = w.data_byte;
      run_items.delete();
      if (w.byte_present) begin
         if (escape_next) begin
            add_item(KindByte, c);
            in_word     = 1'b1;
            escape_next = 1'b0;
         end else if (quote_state == ModeDouble) begin
            if (dq_backslash) begin
               // Only a few bytes swallow the backslash inside double quotes.
               dq_backslash = 1'b0;
               if (!(c == ChDquote || c == ChBackslash || c == ChDollar ||
                     c == ChBacktick || c == ChNewline))
                  add_item(KindByte, ChBackslash);
               add_item(KindByte, c);
            end else if (c == ChDquote) begin
               quote_state = ModePlain;
            end else if (c == ChBackslash) begin
               dq_backslash = 1'b1;
            end else begin
               add_item(KindByte, c);
            end
         end else if (quote_state == ModeSingle) begin
            if (c == ChSquote)
               quote_state = ModePlain;
            else
               add_item(KindByte, c);
         end else if (c == ChSpace || c == ChTab || c == ChNewline) begin
            end_word();
         end else if (c == ChDquote) begin
            quote_state = ModeDouble;
            in_word     = 1'b1;
         end else if (c == ChSquote) begin
            quote_state = ModeSingle;
            in_word     = 1'b1;
         end else if (c == ChBackslash) begin
            escape_next = 1'b1;
            in_word     = 1'b1;
         end else begin
            add_item(KindByte, c);
            in_word = 1'b1;
         end
      end
      // The end of payload is handled after the byte of the same word.
      if (w.end_of_payload) begin
         if (escape_next) begin
            add_item(KindErrBackslash, 8'h00);
         end else if (quote_state == ModeDouble || quote_state == ModeSingle ||
                      dq_backslash) begin
            add_item(KindErrQuote, 8'h00);
         end else begin
            end_word();
            add_item(word_done ? KindDone : KindErrEmpty, 8'h00);
         end
         clear_state();
      end
      if (run_items.size() > 0) begin
         run_items[run_items.size() - 1].last_of_run = 1'b1;
         predicted_tokens = {predicted_tokens, run_items};
      end
   endfunction

   // Compares each popped token with the oldest prediction, then predicts for the
   // word taken in at the same edge.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         clear_state();
         predicted_tokens.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (predicted_tokens.size() == 0) begin
               $error("unexpected token: item_kind %0d, word_byte %02h, last_of_run %0d",
                      rsp_word.item_kind, rsp_word.word_byte, rsp_word.last_of_run);
               mismatches++;
            end else begin
               want = predicted_tokens.pop_front();
               if (rsp_word.item_kind !== want.item_kind) begin
                  $error("item_kind: expected %0d, actual %0d",
                         want.item_kind, rsp_word.item_kind);
                  mismatches++;
               end
               if (rsp_word.word_byte !== want.word_byte) begin
                  $error("word_byte: expected %02h, actual %02h",
                         want.word_byte, rsp_word.word_byte);
                  mismatches++;
               end
               if (rsp_word.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %0d, actual %0d",
                         want.last_of_run, rsp_word.last_of_run);
                  mismatches++;
               end
            end
         end
         if (req_push && !req_full)
            tokenize_word(req_word);
      end
      fail_count <= mismatches;
      pending    <= predicted_tokens.size();
   end

endmodule

// ----- test/shell_word_tokenizer_top_tb.sv -----
`timescale 1ns / 1ps

module shell_word_tokenizer_top_tb;
   import swt_pkg::*;

   localparam int StallLimit  = 2000;
   localparam int HoldOff     = 250;
   localparam int TargetWords = 310;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   req_type req_word  = '0;
   logic    rsp_pop   = 1'b0;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_word;
   int      fail_count;
   int      pending;

   int         words_sent = 0;
   bit         no_gaps    = 1'b0;
   logic [7:0] text[$];

   shell_word_tokenizer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_word  (req_word),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_word  (rsp_word)
   );

   shell_word_tokenizer_checker checker_inst (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_word   (req_word),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_word   (rsp_word),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Appends one byte to the payload being built.
   function automatic void append_text(logic [7:0] v);
      text = {text, v};
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      else if (r < 92)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] special_byte();
      case ($urandom_range(0, 7))
         0: return ChSpace;
         1: return ChTab;
         2: return ChNewline;
         3: return ChDquote;
         4: return ChSquote;
         5: return ChBackslash;
         6: return ChDollar;
         default: return ChBacktick;
      endcase
   endfunction

   function automatic logic [7:0] any_byte();
      logic [7:0] b;
      b = 8'($urandom_range(0, 255));
      if ($urandom_range(0, 9) < 4)
         b = special_byte();
      return b;
   endfunction

   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      b = 8'(8'h61 + $urandom_range(0, 25));
      if ($urandom_range(0, 4) == 0)
         b = 8'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic req_type make_word(logic [7:0] b, logic present, logic last);
      req_type w;
      w.data_byte      = b;
      w.byte_present   = present;
      w.end_of_payload = last;
      return w;
   endfunction

   // Offers one word, after an optional gap, and waits until it is taken.
   task automatic send_word(req_type w);
      int gap;
      gap = no_gaps ? 0 : idle_length();
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word <= w;
      req_push <= 1'b1;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if (w.byte_present || w.end_of_payload)
         words_sent++;
   endtask

   // Sends the bytes held in text as one payload; the end either rides on the last
   // byte or comes as a bare marker.
   task automatic send_payload();
      bit bare_end;
      bare_end = 1'($urandom_range(0, 1));
      foreach (text[i]) begin
         send_word(make_word(text[i], 1'b1, !bare_end && i == text.size() - 1));
         if ($urandom_range(0, 19) == 0)
            send_word(make_word(8'($urandom_range(0, 255)), 1'b0, 1'b0));
      end
      if (bare_end || text.size() == 0)
         send_word(make_word(8'($urandom_range(0, 255)), 1'b0, 1'b1));
      text.delete();
   endtask

   // Stimulus and verdict.
   initial begin : stimulus
      logic [7:0] b;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Extreme bytes, a tab separator, an empty single-quoted word, newline at the end.
      send_word(make_word(8'h00, 1'b1, 1'b0));
      send_word(make_word(8'hFF, 1'b1, 1'b0));
      send_word(make_word(ChTab, 1'b1, 1'b0));
      send_word(make_word(ChSquote, 1'b1, 1'b0));
      send_word(make_word(ChSquote, 1'b1, 1'b0));
      send_word(make_word(ChNewline, 1'b1, 1'b1));
      // Double-quoted escapes, the kept backslash, and an unquoted literal space.
      send_word(make_word(ChDquote, 1'b1, 1'b0));
      send_word(make_word(ChBackslash, 1'b1, 1'b0));
      send_word(make_word(ChDollar, 1'b1, 1'b0));
      send_word(make_word(ChBackslash, 1'b1, 1'b0));
      send_word(make_word(8'h78, 1'b1, 1'b0));
      send_word(make_word(ChBackslash, 1'b1, 1'b0));
      send_word(make_word(ChDquote, 1'b1, 1'b0));
      send_word(make_word(ChDquote, 1'b1, 1'b0));
      send_word(make_word(ChBackslash, 1'b1, 1'b0));
      send_word(make_word(ChSpace, 1'b1, 1'b1));
      // Trailing backslash.
      send_word(make_word(ChBackslash, 1'b1, 1'b1));
      // Unterminated double quote.
      send_word(make_word(ChDquote, 1'b1, 1'b1));
      // Escape pending inside double quotes at the end.
      send_word(make_word(ChDquote, 1'b1, 1'b0));
      send_word(make_word(ChBackslash, 1'b1, 1'b1));
      // Empty list: an ignored bare marker, a lone separator, then a bare end.
      send_word(make_word(8'hA5, 1'b0, 1'b0));
      send_word(make_word(ChSpace, 1'b1, 1'b0));
      send_word(make_word(8'h5A, 1'b0, 1'b1));
      // A backslash inside single quotes is raw; the quote is left open.
      send_word(make_word(ChSquote, 1'b1, 1'b0));
      send_word(make_word(ChBackslash, 1'b1, 1'b1));

      // Random payloads, mostly built from well-formed fragments.
      while (words_sent < TargetWords) begin
         if ($urandom_range(0, 7) == 0)
            no_gaps = ~no_gaps;
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 8)) append_text(any_byte());
         end else begin
            repeat ($urandom_range(1, 4)) begin
               case ($urandom_range(0, 3))
                  0, 1: begin
                     repeat ($urandom_range(1, 4)) begin
                        if ($urandom_range(0, 5) == 0) begin
                           append_text(ChBackslash);
                           append_text(any_byte());
                        end else begin
                           append_text(plain_byte());
                        end
                     end
                  end
                  2: begin
                     append_text(ChSquote);
                     repeat ($urandom_range(0, 4)) begin
                        b = any_byte();
                        if (b == ChSquote)
                           b = 8'h71;
                        append_text(b);
                     end
                     append_text(ChSquote);
                  end
                  default: begin
                     append_text(ChDquote);
                     repeat ($urandom_range(0, 4)) begin
                        if ($urandom_range(0, 2) == 0) begin
                           append_text(ChBackslash);
                           append_text(any_byte());
                        end else begin
                           b = any_byte();
                           if (b == ChDquote || b == ChBackslash)
                              b = 8'h2E;
                           append_text(b);
                        end
                     end
                     append_text(ChDquote);
                  end
               endcase
               if ($urandom_range(0, 3) != 0) begin
                  case ($urandom_range(0, 2))
                     0: append_text(ChSpace);
                     1: append_text(ChTab);
                     default: append_text(ChNewline);
                  endcase
               end
            end
         end
         send_payload();
      end
      req_push <= 1'b0;

      // Drain, then allow a few cycles for anything extra to show.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Result side: runs of pops with gaps between them, and one long hold-off so that
   // the block fills up and stalls its input.
   initial begin : drain
      int  run_len;
      int  stall;
      int  elapsed;
      bit  held;
      held    = 1'b0;
      elapsed = 0;
      wait (!reset);
      @(posedge clock);
      forever begin
         run_len = $urandom_range(1, 20);
         rsp_pop <= 1'b1;
         repeat (run_len) @(posedge clock);
         elapsed += run_len;
         if (!held && elapsed >= 300) begin
            stall = HoldOff;
            held  = 1'b1;
         end else begin
            stall = idle_length();
         end
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
            elapsed += stall;
         end
      end
   end

   // Ends the run if no word moves on either side for too long.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < StallLimit) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
            quiet = 0;
         else
            quiet++;
      end
      $display("FAILURE");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/swt_pkg.sv
rtl/swt_front.sv
rtl/swt_queue.sv
rtl/swt_back.sv
rtl/shell_word_tokenizer_top.sv
test/shell_word_tokenizer_checker.sv
test/shell_word_tokenizer_top_tb.sv
